// ===== design/mes_pkg.sv =====
package mes_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int DATA_W       = 32;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   // one frame per level of the split tree, plus the root
   localparam int STACK_DEPTH  = IDX_W + 1;
   localparam int SP_W         = $clog2(STACK_DEPTH);

   // what a returned winner means when its parent frame resumes
   typedef enum logic [1:0] {
      PH_LEFT,
      PH_RIGHT
   } phase_type;

   typedef struct packed {
      logic [IDX_W-1:0]  lo;
      logic [IDX_W-1:0]  hi;
      phase_type         phase;
      logic [DATA_W-1:0] left;
   } frame_type;

endpackage

// ===== design/mes_ram.sv =====
module mes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/majority_element_select.sv =====
// majority element select: items are list elements, taken one per cycle while
// busy is low and written straight into a 1024-entry element ram; items past
// capacity are dropped and reported with the result. the item with req_last
// set closes the list, raises busy and starts the evaluation, which walks the
// split tree depth first with a small frame stack in flops. every range is
// entered going down and left coming back, a single-element range with a ram
// read between, and each node whose half winners differ then scans its whole
// range through the single ram read port before it tallies and decides. the
// ram read port is the limit on the whole evaluation. the winner shows on
// rsp_winner with rsp_strobe high for exactly one cycle; the receiver cannot
// stall, so it must take the item in that cycle. busy falls in that same
// cycle and a new list may start right away
module majority_element_select (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [31:0] rsp_winner,
   output logic        rsp_overflowed
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALL,
      S_LEAF,
      S_RETURN,
      S_COUNT,
      S_TALLY,
      S_DECIDE
   } state_type;

   localparam int IDX_W  = mes_pkg::IDX_W;
   localparam int CNT_W  = mes_pkg::CNT_W;
   localparam int SP_W   = mes_pkg::SP_W;
   localparam int DATA_W = mes_pkg::DATA_W;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 dropped_ff, dropped_in;
   logic [IDX_W-1:0]     lo_ff, lo_in;
   logic [IDX_W-1:0]     hi_ff, hi_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [DATA_W-1:0]    left_ff, left_in;
   logic [DATA_W-1:0]    right_ff, right_in;
   logic [DATA_W-1:0]    ret_ff, ret_in;
   logic [CNT_W-1:0]     cnt_l_ff, cnt_l_in;
   logic [CNT_W-1:0]     cnt_r_ff, cnt_r_in;
   logic [SP_W-1:0]      sp_ff, sp_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 strobe_ff, strobe_in;
   logic [DATA_W-1:0]    winner_ff, winner_in;
   logic                 ovf_ff, ovf_in;

   mes_pkg::frame_type   stack_ff [mes_pkg::STACK_DEPTH];
   mes_pkg::frame_type   stk_wd;
   mes_pkg::frame_type   top;
   logic                 stk_we;
   logic [SP_W-1:0]      stk_wa;
   logic [SP_W-1:0]      sp_m1;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic                 ram_re;
   logic [IDX_W-1:0]     ram_raddr;
   logic [DATA_W-1:0]    ram_rdata;

   logic [IDX_W-1:0]     mid_cur;
   logic [IDX_W-1:0]     mid_top;
   logic                 has_room;

   mes_ram #(
      .WIDTH (DATA_W),
      .DEPTH (mes_pkg::MAX_ELEMENTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_value),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign sp_m1    = sp_ff - SP_W'(1);
   assign top      = stack_ff[sp_m1];
   assign mid_cur  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mid_top  = top.lo + ((top.hi - top.lo) >> 1);
   assign has_room = fill_ff < CNT_W'(mes_pkg::MAX_ELEMENTS);
   assign ram_waddr = fill_ff[IDX_W-1:0];

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      idx_in     = idx_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      ret_in     = ret_ff;
      cnt_l_in   = cnt_l_ff;
      cnt_r_in   = cnt_r_ff;
      sp_in      = sp_ff;
      rd_vld_in  = 1'b0;
      strobe_in  = 1'b0;
      winner_in  = winner_ff;
      ovf_in     = ovf_ff;
      stk_we     = 1'b0;
      stk_wa     = sp_ff;
      stk_wd     = top;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_raddr  = lo_ff;

      // tally stream, fed by the registered read of the previous scan address
      if (rd_vld_ff) begin
         if (ram_rdata == left_ff) begin
            cnt_l_in = cnt_l_ff + CNT_W'(1);
         end
         if (ram_rdata == right_ff) begin
            cnt_r_in = cnt_r_ff + CNT_W'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (has_room) begin
                  ram_we  = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  lo_in    = '0;
                  hi_in    = has_room ? fill_ff[IDX_W-1:0]
                                      : IDX_W'(mes_pkg::MAX_ELEMENTS - 1);
                  sp_in    = '0;
                  state_in = S_CALL;
               end
            end
         end
         S_CALL: begin
            if (lo_ff == hi_ff) begin
               ram_re    = 1'b1;
               ram_raddr = lo_ff;
               state_in  = S_LEAF;
            end else begin
               // descend into the left half, remember this range
               stk_we       = 1'b1;
               stk_wa       = sp_ff;
               stk_wd.lo    = lo_ff;
               stk_wd.hi    = hi_ff;
               stk_wd.phase = mes_pkg::PH_LEFT;
               stk_wd.left  = left_ff;
               sp_in        = sp_ff + SP_W'(1);
               hi_in        = mid_cur;
            end
         end
         S_LEAF: begin
            ret_in   = ram_rdata;
            state_in = S_RETURN;
         end
         S_RETURN: begin
            if (sp_ff == '0) begin
               strobe_in  = 1'b1;
               winner_in  = ret_ff;
               ovf_in     = dropped_ff;
               fill_in    = '0;
               dropped_in = 1'b0;
               state_in   = S_IDLE;
            end else if (top.phase == mes_pkg::PH_LEFT) begin
               // left winner known, rewrite frame in place and go right
               stk_we       = 1'b1;
               stk_wa       = sp_m1;
               stk_wd.lo    = top.lo;
               stk_wd.hi    = top.hi;
               stk_wd.phase = mes_pkg::PH_RIGHT;
               stk_wd.left  = ret_ff;
               lo_in        = mid_top + IDX_W'(1);
               hi_in        = top.hi;
               state_in     = S_CALL;
            end else begin
               sp_in    = sp_m1;
               lo_in    = top.lo;
               hi_in    = top.hi;
               left_in  = top.left;
               right_in = ret_ff;
               if (top.left != ret_ff) begin
                  idx_in   = top.lo;
                  cnt_l_in = '0;
                  cnt_r_in = '0;
                  state_in = S_COUNT;
               end
            end
         end
         S_COUNT: begin
            ram_re    = 1'b1;
            ram_raddr = idx_ff;
            rd_vld_in = 1'b1;
            idx_in    = idx_ff + IDX_W'(1);
            if (idx_ff == hi_ff) begin
               state_in = S_TALLY;
            end
         end
         S_TALLY: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // tie goes to the right candidate
            ret_in   = (cnt_l_ff > cnt_r_ff) ? left_ff : right_ff;
            state_in = S_RETURN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
         sp_ff      <= '0;
         rd_vld_ff  <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
         sp_ff      <= sp_in;
         rd_vld_ff  <= rd_vld_in;
         strobe_ff  <= strobe_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      ret_ff    <= ret_in;
      cnt_l_ff  <= cnt_l_in;
      cnt_r_ff  <= cnt_r_in;
      winner_ff <= winner_in;
      ovf_ff    <= ovf_in;
   end

   // frame stack, payload only
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_ff[stk_wa] <= stk_wd;
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_winner     = winner_ff;
   assign rsp_overflowed = ovf_ff;

   // a result only ever closes an evaluation
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without evaluation");

   // at most one result per list
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result repeated");

   // stack never deeper than the split tree
   assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(IDX_W))
      else $error("frame stack overflow");

   // ranges entered are never inverted
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALL) |-> (lo_ff <= hi_ff))
      else $error("inverted range");

   // scan stays inside the current range
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COUNT) |-> (idx_ff >= lo_ff && idx_ff <= hi_ff))
      else $error("scan out of range");

endmodule

// ===== sim/majority_element_select_checker.sv =====
module majority_element_select_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [mes_pkg::DATA_W-1:0] req_value,
   input  logic                       req_last,
   input  logic                       rsp_strobe,
   input  logic [mes_pkg::DATA_W-1:0] rsp_winner,
   input  logic                       rsp_overflowed,
   output int                         error_count,
   output int                         winners_pending,
   output int                         lists_closed,
   output int                         overflow_lists
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [mes_pkg::DATA_W-1:0] winner;
      logic                       overflowed;
   } outcome_type;

   logic [mes_pkg::DATA_W-1:0] list_store [mes_pkg::MAX_ELEMENTS];
   int                         fill_level;
   logic                       drop_seen;
   outcome_type                winner_queue [$];

   function automatic int count_matches(input int lo, input int hi,
                                        input logic [mes_pkg::DATA_W-1:0] cand);
      int n;
      n = 0;
      for (int i = lo; i <= hi; i++) begin
         if (list_store[i] == cand) begin
            n++;
         end
      end
      return n;
   endfunction

   // split tree walked depth first with an explicit frame stack
   function automatic logic [mes_pkg::DATA_W-1:0] majority_pick(input int n_stored);
      int                         lo_at    [mes_pkg::STACK_DEPTH+1];
      int                         hi_at    [mes_pkg::STACK_DEPTH+1];
      logic [mes_pkg::DATA_W-1:0] left_at  [mes_pkg::STACK_DEPTH+1];
      logic                       right_due[mes_pkg::STACK_DEPTH+1];
      int                         top, lo, hi, mid;
      logic                       returning;
      logic [mes_pkg::DATA_W-1:0] carried;
      top       = 0;
      lo_at[0]  = 0;
      hi_at[0]  = n_stored - 1;
      returning = 1'b0;
      carried   = '0;
      while (top >= 0) begin
         lo  = lo_at[top];
         hi  = hi_at[top];
         mid = lo + (hi - lo) / 2;
         if (!returning) begin
            if (lo >= hi) begin
               carried   = list_store[lo];
               returning = 1'b1;
               top--;
            end else begin
               right_due[top] = 1'b0;
               top++;
               lo_at[top] = lo;
               hi_at[top] = mid;
            end
         end else if (!right_due[top]) begin
            left_at[top]   = carried;
            right_due[top] = 1'b1;
            returning      = 1'b0;
            top++;
            lo_at[top] = mid + 1;
            hi_at[top] = hi;
         end else begin
            // tie goes to the right half winner
            if (left_at[top] != carried &&
                count_matches(lo, hi, left_at[top]) > count_matches(lo, hi, carried)) begin
               carried = left_at[top];
            end
            top--;
         end
      end
      return carried;
   endfunction

   always @(posedge clock) begin
      outcome_type want, seen;
      if (reset) begin
         fill_level     = 0;
         drop_seen      = 1'b0;
         error_count    = 0;
         lists_closed   = 0;
         overflow_lists = 0;
         winner_queue.delete();
      end else begin
         // results first: an item taken at this edge cannot answer at it
         if (rsp_strobe) begin
            seen.winner     = rsp_winner;
            seen.overflowed = rsp_overflowed;
            if (winner_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got winner %h overflowed %b",
                        $time, seen.winner, seen.overflowed);
            end else begin
               want = winner_queue.pop_front();
               if (seen.winner !== want.winner) begin
                  error_count++;
                  $display("%0t: winner mismatch, expected %h, got %h",
                           $time, want.winner, seen.winner);
               end
               if (seen.overflowed !== want.overflowed) begin
                  error_count++;
                  $display("%0t: overflowed mismatch, expected %b, got %b",
                           $time, want.overflowed, seen.overflowed);
               end
            end
         end
         if (start && !busy) begin
            if (fill_level < mes_pkg::MAX_ELEMENTS) begin
               list_store[fill_level] = req_value;
               fill_level++;
            end else begin
               drop_seen = 1'b1;
            end
            if (req_last) begin
               want.winner     = majority_pick(fill_level);
               want.overflowed = drop_seen;
               winner_queue.push_back(want);
               lists_closed++;
               if (drop_seen) begin
                  overflow_lists++;
               end
               fill_level = 0;
               drop_seen  = 1'b0;
            end
         end
      end
      winners_pending = winner_queue.size();
   end

endmodule

// ===== sim/majority_element_select_tb.sv =====
module majority_element_select_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // rough item budget per idle phase; the store-filling list goes in the last
   localparam int PHASE_ITEMS  = 280;
   localparam int TOTAL_ITEMS  = 1600;
   localparam int CYCLE_LIMIT  = 400000;
   // quiet cycles after the last winner to catch stray strobes
   localparam int DRAIN_CYCLES = 64;

   typedef enum {
      FEW_VALUES,   // items drawn from a pool of up to four values
      DOMINANT,     // one value in about 60 percent of items
      SCATTERED     // every item independent
   } list_shape_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [mes_pkg::DATA_W-1:0] req_value;
   logic                       req_last;
   logic                       rsp_strobe;
   logic [mes_pkg::DATA_W-1:0] rsp_winner;
   logic                       rsp_overflowed;

   int error_count;
   int winners_pending;
   int lists_closed;
   int overflow_lists;
   int cycle_count = 0;
   int items_sent  = 0;
   int sender_idle_pct;

   majority_element_select i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_last       (req_last),
      .rsp_strobe     (rsp_strobe),
      .rsp_winner     (rsp_winner),
      .rsp_overflowed (rsp_overflowed)
   );

   // watches both channels, predicts winners and counts mismatches
   majority_element_select_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_strobe      (rsp_strobe),
      .rsp_winner      (rsp_winner),
      .rsp_overflowed  (rsp_overflowed),
      .error_count     (error_count),
      .winners_pending (winners_pending),
      .lists_closed    (lists_closed),
      .overflow_lists  (overflow_lists)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hung evaluation or a lost winner ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: no progress within %0d cycles, %0d winners still owed",
                  $time, CYCLE_LIMIT, winners_pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // extremes show up often so sign and all-ones patterns get exercised
   function automatic logic [mes_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // mostly short lists, now and then a long one
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         return $urandom_range(1, 12);
      end else if (roll < 95) begin
         return $urandom_range(13, 64);
      end
      return $urandom_range(65, 200);
   endfunction

   // one item: random idle cycles first, then hold start until busy is low
   task automatic send_item(input logic [mes_pkg::DATA_W-1:0] value, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start     = 1'b0;
         // noise on the fields while start is low
         req_value = $urandom;
         req_last  = 1'($urandom_range(1));
      end
      @(negedge clock);
      start     = 1'b1;
      req_value = value;
      req_last  = last;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic send_list(input int len);
      logic [mes_pkg::DATA_W-1:0] pool [4];
      int                         pool_size;
      list_shape_type             shape;
      logic [mes_pkg::DATA_W-1:0] value;
      foreach (pool[k]) begin
         pool[k] = pick_value();
      end
      pool_size = $urandom_range(1, 4);
      shape     = list_shape_type'($urandom_range(2));
      for (int i = 0; i < len; i++) begin
         case (shape)
            FEW_VALUES: value = pool[$urandom_range(pool_size - 1)];
            DOMINANT:   value = ($urandom_range(99) < 60) ? pool[0] : pick_value();
            default:    value = pick_value();
         endcase
         send_item(value, i == len - 1);
      end
   endtask

   // sender holds off until every owed winner has come back
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (winners_pending != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_value       = '0;
      req_last        = 1'b0;
      sender_idle_pct = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-item lists at the value extremes
      send_item(32'h8000_0000, 1'b1);
      send_item(32'h7fff_ffff, 1'b1);
      send_item(32'h0000_0000, 1'b1);
      send_item(32'hffff_ffff, 1'b1);
      // two unequal items: tie goes to the right one
      send_item(32'd5, 1'b0);
      send_item(32'd9, 1'b1);
      // unequal halves settled by the count over the whole range
      send_item(32'd7, 1'b0);
      send_item(32'd3, 1'b0);
      send_item(32'd7, 1'b1);
      // no majority present at all
      send_item(32'd1, 1'b0);
      send_item(32'd2, 1'b0);
      send_item(32'd3, 1'b0);
      send_item(32'd4, 1'b1);
      // values that differ only in the sign bit
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h0000_0000, 1'b0);
      send_item(32'h8000_0000, 1'b1);
      // clear majority with alternating bit patterns
      send_item(32'haaaa_aaaa, 1'b0);
      send_item(32'h5555_5555, 1'b0);
      send_item(32'haaaa_aaaa, 1'b0);
      send_item(32'haaaa_aaaa, 1'b1);
      wait_drained();

      // sender idles 28 then 48 percent of cycles, then not at all
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 48 : 0;
         if (phase == 2) begin
            // fills the store, the last one or two items get dropped
            send_list(mes_pkg::MAX_ELEMENTS + $urandom_range(1, 2));
         end
         while (items_sent < ((phase < 2) ? items_sent + 1 : 0) &&
                items_sent < 20 + (phase + 1) * PHASE_ITEMS ||
                phase == 2 && items_sent < TOTAL_ITEMS) begin
            send_list(pick_length());
            if ($urandom_range(29) == 0) begin
               wait_drained();
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d items in %0d lists, %0d of them past the %0d-entry store",
               items_sent, lists_closed, overflow_lists, mes_pkg::MAX_ELEMENTS);
      $display("sender idle at 28, 48 and 0 percent, with a full drain now and then");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/mes_pkg.sv
design/mes_ram.sv
design/majority_element_select.sv
sim/majority_element_select_checker.sv
sim/majority_element_select_tb.sv
